// ----- hdl/rect_point_segment_box_hit_test_top_macros.svh -----
// Assertion macros shared by the hit tester RTL.
`ifndef RECT_POINT_SEGMENT_BOX_HIT_TEST_TOP_MACROS_SVH
`define RECT_POINT_SEGMENT_BOX_HIT_TEST_TOP_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define RPSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpsb_hit: same-cycle check failed");

// Next-cycle implication, checked while reset is low.
`define RPSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpsb_hit: next-cycle check failed");

`endif

// ----- hdl/rpsb_hit_pkg.sv -----
// Types, constants and helper functions of the rectangle hit tester.
package rpsb_hit_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIM_BITS = 15;
   // Wide enough for a coordinate plus a width or height without overflow.
   localparam int EXT_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1) + 1;
   // Differences of two extended coordinates.
   localparam int DIFF_BITS = EXT_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int NUM_CORNERS = 4;

   // Corner order around the rectangle, closed back to the first corner.
   localparam int EDGE_CORNER [5] = '{0, 1, 2, 3, 0};

   typedef enum logic [1:0] {
      MODE_POINT   = 2'd0,
      MODE_SEGMENT = 2'd1,
      MODE_BOX     = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RECT_X = 2'd0,
      CSR_RECT_Y = 2'd1,
      CSR_RECT_W = 2'd2,
      CSR_RECT_H = 2'd3
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIM_BITS-1:0] dim_type;
   typedef logic signed [EXT_BITS-1:0] ext_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

   typedef struct packed {
      logic neg;
      logic pos;
   } sign_type;

   function automatic ext_type sext_coord(input coord_type c);
      return EXT_BITS'(c);
   endfunction

   function automatic ext_type zext_dim(input dim_type d);
      return $signed(EXT_BITS'(d));
   endfunction

   function automatic diff_type diff_of(input ext_type a, input ext_type b);
      return DIFF_BITS'(a) - DIFF_BITS'(b);
   endfunction

   // Exact sign of a*b + c*d.
   function automatic sign_type cross_sign(input diff_type a, input diff_type b,
                                           input diff_type c, input diff_type d);
      logic signed [PROD_BITS-1:0] p;
      logic signed [PROD_BITS-1:0] q;
      logic signed [PROD_BITS:0] s;
      sign_type r;
      p = a * b;
      q = c * d;
      s = (PROD_BITS + 1)'(p) + (PROD_BITS + 1)'(q);
      r.neg = s[PROD_BITS];
      r.pos = !s[PROD_BITS] && (s != '0);
      return r;
   endfunction

   function automatic logic strictly_opposite(input sign_type a, input sign_type b);
      return (a.pos && b.neg) || (a.neg && b.pos);
   endfunction

endpackage

// ----- hdl/rpsb_hit_ifs.sv -----
// Valid/ready channel interfaces for query words and result words.
interface rpsb_hit_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic signed [rpsb_hit_pkg::COORD_BITS-1:0] first_x;
   logic signed [rpsb_hit_pkg::COORD_BITS-1:0] first_y;
   logic signed [rpsb_hit_pkg::COORD_BITS-1:0] end_x;
   logic signed [rpsb_hit_pkg::COORD_BITS-1:0] end_y;
   logic [rpsb_hit_pkg::DIM_BITS-1:0] other_w;
   logic [rpsb_hit_pkg::DIM_BITS-1:0] other_h;

   modport source (output valid, mode, first_x, first_y, end_x, end_y, other_w, other_h,
                   input ready);
   modport sink (input valid, mode, first_x, first_y, end_x, end_y, other_w, other_h,
                 output ready);
endinterface

interface rpsb_hit_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

// ----- hdl/rect_point_segment_box_hit_test_top.sv -----
// Top level of the axis-aligned rectangle hit tester.
//
// The rectangle (corner rect_x/rect_y, size rect_w/rect_h) is held in four
// registers written through the csr_ port: csr_we high at a rising edge writes
// csr_wdata into the register selected by csr_index. Write them only while the
// block is idle.
// Each query word on req_if asks one question selected by mode: point inside
// (low edges inclusive, high edges exclusive), segment hit (proper crossing of
// an edge, or both endpoints inside the closed rectangle), or box overlap with
// inclusive edges. An unused mode answers with no hit.
// Every query word yields exactly one result word on rsp_if carrying hit.
// A word is moved at a rising edge where valid and ready are both high.
// A query word passes through the input register and the result register to rsp_if;
// throughput is one word per cycle while rsp_if.ready is high, set by a single
// registered pass that evaluates the four corner cross products in parallel.
// When rsp_if.ready is low, the result register holds its word and the input
// register fills; req_if.ready drops only when both are occupied.
// Synchronous reset clears the rectangle registers to zero and empties both
// pipeline registers.
`include "rect_point_segment_box_hit_test_top_macros.svh"

module rect_point_segment_box_hit_test_top (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [rpsb_hit_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rpsb_hit_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   rpsb_hit_req_if.sink req_if,
   rpsb_hit_rsp_if.source rsp_if
);

   // Rectangle registers.
   rpsb_hit_pkg::coord_type rect_x_ff;
   rpsb_hit_pkg::coord_type rect_y_ff;
   rpsb_hit_pkg::dim_type rect_w_ff;
   rpsb_hit_pkg::dim_type rect_h_ff;

   // Input register stage.
   logic s1_valid_ff;
   logic s1_valid_in;
   logic [1:0] s1_mode_ff;
   rpsb_hit_pkg::coord_type s1_px_ff;
   rpsb_hit_pkg::coord_type s1_py_ff;
   rpsb_hit_pkg::coord_type s1_ex_ff;
   rpsb_hit_pkg::coord_type s1_ey_ff;
   rpsb_hit_pkg::dim_type s1_ow_ff;
   rpsb_hit_pkg::dim_type s1_oh_ff;

   // Result register stage.
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic hit_ff;
   logic hit_in;

   logic req_accept;
   logic advance;
   logic hit_calc;

   // The result register can take a new word when it is empty or being drained.
   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   assign s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign hit_in = (advance && s1_valid_ff) ? hit_calc : hit_ff;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.hit = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff <= '0;
         rect_y_ff <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rpsb_hit_pkg::CSR_RECT_X: begin
               rect_x_ff <= csr_wdata[rpsb_hit_pkg::COORD_BITS-1:0];
            end
            rpsb_hit_pkg::CSR_RECT_Y: begin
               rect_y_ff <= csr_wdata[rpsb_hit_pkg::COORD_BITS-1:0];
            end
            rpsb_hit_pkg::CSR_RECT_W: begin
               rect_w_ff <= csr_wdata[rpsb_hit_pkg::DIM_BITS-1:0];
            end
            rpsb_hit_pkg::CSR_RECT_H: begin
               rect_h_ff <= csr_wdata[rpsb_hit_pkg::DIM_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff <= req_if.mode;
         s1_px_ff <= req_if.first_x;
         s1_py_ff <= req_if.first_y;
         s1_ex_ff <= req_if.end_x;
         s1_ey_ff <= req_if.end_y;
         s1_ow_ff <= req_if.other_w;
         s1_oh_ff <= req_if.other_h;
      end
      hit_ff <= hit_in;
   end

   // Hit evaluation on the registered query word.
   rpsb_hit_pkg::ext_type rx;
   rpsb_hit_pkg::ext_type ry;
   rpsb_hit_pkg::ext_type rr;
   rpsb_hit_pkg::ext_type rb;
   rpsb_hit_pkg::ext_type px;
   rpsb_hit_pkg::ext_type py;
   rpsb_hit_pkg::ext_type ex;
   rpsb_hit_pkg::ext_type ey;
   rpsb_hit_pkg::ext_type box_r;
   rpsb_hit_pkg::ext_type box_b;
   rpsb_hit_pkg::ext_type corner_x [rpsb_hit_pkg::NUM_CORNERS];
   rpsb_hit_pkg::ext_type corner_y [rpsb_hit_pkg::NUM_CORNERS];
   rpsb_hit_pkg::diff_type seg_dx;
   rpsb_hit_pkg::diff_type seg_dy;
   rpsb_hit_pkg::sign_type corner_side [rpsb_hit_pkg::NUM_CORNERS];
   logic [rpsb_hit_pkg::NUM_CORNERS-1:0] edge_cross;
   logic point_hit;
   logic start_inside;
   logic end_inside;
   logic segment_hit;
   logic box_hit;

   always_comb begin
      rx = rpsb_hit_pkg::sext_coord(rect_x_ff);
      ry = rpsb_hit_pkg::sext_coord(rect_y_ff);
      rr = rx + rpsb_hit_pkg::zext_dim(rect_w_ff);
      rb = ry + rpsb_hit_pkg::zext_dim(rect_h_ff);
      px = rpsb_hit_pkg::sext_coord(s1_px_ff);
      py = rpsb_hit_pkg::sext_coord(s1_py_ff);
      ex = rpsb_hit_pkg::sext_coord(s1_ex_ff);
      ey = rpsb_hit_pkg::sext_coord(s1_ey_ff);
      box_r = px + rpsb_hit_pkg::zext_dim(s1_ow_ff);
      box_b = py + rpsb_hit_pkg::zext_dim(s1_oh_ff);

      corner_x[0] = rx;
      corner_y[0] = ry;
      corner_x[1] = rr;
      corner_y[1] = ry;
      corner_x[2] = rr;
      corner_y[2] = rb;
      corner_x[3] = rx;
      corner_y[3] = rb;

      seg_dx = rpsb_hit_pkg::diff_of(px, ex);
      seg_dy = rpsb_hit_pkg::diff_of(py, ey);

      // Side of each corner relative to the segment's line.
      for (int k = 0; k < rpsb_hit_pkg::NUM_CORNERS; k++) begin
         corner_side[k] = rpsb_hit_pkg::cross_sign(
            seg_dx, rpsb_hit_pkg::diff_of(corner_y[k], py),
            seg_dy, rpsb_hit_pkg::diff_of(px, corner_x[k]));
      end

      // An edge is crossed properly when its two corners lie strictly on
      // opposite sides of the segment and the segment's endpoints lie strictly
      // on opposite sides of a nonzero-length edge. Even edges are horizontal.
      for (int i = 0; i < rpsb_hit_pkg::NUM_CORNERS; i++) begin
         if ((i % 2) == 0) begin
            edge_cross[i] =
               rpsb_hit_pkg::strictly_opposite(
                  corner_side[rpsb_hit_pkg::EDGE_CORNER[i+1]],
                  corner_side[rpsb_hit_pkg::EDGE_CORNER[i]]) &&
               (rect_w_ff != '0) &&
               (((py > corner_y[rpsb_hit_pkg::EDGE_CORNER[i+1]]) &&
                 (ey < corner_y[rpsb_hit_pkg::EDGE_CORNER[i+1]])) ||
                ((py < corner_y[rpsb_hit_pkg::EDGE_CORNER[i+1]]) &&
                 (ey > corner_y[rpsb_hit_pkg::EDGE_CORNER[i+1]])));
         end else begin
            edge_cross[i] =
               rpsb_hit_pkg::strictly_opposite(
                  corner_side[rpsb_hit_pkg::EDGE_CORNER[i+1]],
                  corner_side[rpsb_hit_pkg::EDGE_CORNER[i]]) &&
               (rect_h_ff != '0) &&
               (((px > corner_x[rpsb_hit_pkg::EDGE_CORNER[i+1]]) &&
                 (ex < corner_x[rpsb_hit_pkg::EDGE_CORNER[i+1]])) ||
                ((px < corner_x[rpsb_hit_pkg::EDGE_CORNER[i+1]]) &&
                 (ex > corner_x[rpsb_hit_pkg::EDGE_CORNER[i+1]])));
         end
      end

      point_hit = (px >= rx) && (py >= ry) && (px < rr) && (py < rb);
      start_inside = (px >= rx) && (px <= rr) && (py >= ry) && (py <= rb);
      end_inside = (ex >= rx) && (ex <= rr) && (ey >= ry) && (ey <= rb);
      segment_hit = (|edge_cross) || (start_inside && end_inside);
      box_hit = (px <= rr) && (box_r >= rx) && (py <= rb) && (box_b >= ry);

      case (s1_mode_ff)
         rpsb_hit_pkg::MODE_POINT: begin
            hit_calc = point_hit;
         end
         rpsb_hit_pkg::MODE_SEGMENT: begin
            hit_calc = segment_hit;
         end
         rpsb_hit_pkg::MODE_BOX: begin
            hit_calc = box_hit;
         end
         default: begin
            hit_calc = 1'b0;
         end
      endcase
   end

   // An accepted query word always lands in the input register.
   `RPSB_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_accept, s1_valid_ff)

   // A stalled query word is neither lost nor passed on.
   `RPSB_ASSERT_NEXT(a_stall_holds_s1, clock, reset, s1_valid_ff && !advance,
                     s1_valid_ff && rsp_valid_ff)

   // An unused mode never produces a hit.
   `RPSB_ASSERT_NEXT(a_unused_mode_no_hit, clock, reset,
                     s1_valid_ff && advance &&
                     !(s1_mode_ff == rpsb_hit_pkg::MODE_POINT ||
                       s1_mode_ff == rpsb_hit_pkg::MODE_SEGMENT ||
                       s1_mode_ff == rpsb_hit_pkg::MODE_BOX),
                     !rsp_if.hit)

   // The input side stalls only while both stages hold words.
   `RPSB_ASSERT_NOW(a_ready_only_full, clock, reset, !req_if.ready,
                    s1_valid_ff && rsp_valid_ff)

endmodule
